>>> design/eiec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eiec_pkg: shared types and constants of the external interrupt controller
// Holds the request payload types, the register indexes and line grouping.
// ----------------------------------------------------------------------------
package eiec_pkg;

	localparam int NUM_PORTS       = 4;
	localparam int NUM_LINES       = 16;
	localparam int LINE_CAP        = 16;
	localparam int SEL_W           = 4;
	localparam int IRQ_W           = 7;
	localparam int DIRECT_LINES    = 5;
	localparam int LAST_SHARED_LOW = 9;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_UNMASK    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISING_ENABLE  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALLING_ENABLE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_SELECT    = 4'd3;

	typedef struct packed {
		logic [15:0] port0_levels;
		logic [15:0] port1_levels;
		logic [15:0] port2_levels;
		logic [15:0] port3_levels;
		logic [15:0] clear_mask;
	} in_item_t;

	typedef struct packed {
		logic [15:0]      pending_flags;
		logic [IRQ_W-1:0] irq_lines;
	} out_item_t;

	// Per-line configuration handed to each lane.
	typedef struct packed {
		logic             rise_en;
		logic             fall_en;
		logic [SEL_W-1:0] sel;
	} lane_cfg_t;

endpackage

>>> design/eiec_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eiec_lane: one interrupt line
// Selects the line level from its source port, detects edges and keeps the
// pending flag and the previous level.
// ----------------------------------------------------------------------------
module eiec_lane import eiec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [NUM_PORTS-1:0] pins,
	input  logic                 clear,
	input  lane_cfg_t            cfg,
	output logic                 pend_next
);

	logic level;
	logic prev_level_q;
	logic pend_q;
	logic edge_hit;

	// A selector past the last present port leaves the level at zero.
	always_comb begin
		level = 1'b0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (cfg.sel == SEL_W'(p)) begin
				level = pins[p];
			end
		end
	end

	assign edge_hit  = (level & ~prev_level_q & cfg.rise_en) |
	                   (~level & prev_level_q & cfg.fall_en);
	// Clear goes first so an edge in the same request still latches.
	assign pend_next = (pend_q & ~clear) | edge_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			pend_q       <= 1'b0;
		end else if (advance) begin
			prev_level_q <= level;
			pend_q       <= pend_next;
		end
	end

endmodule

>>> design/eiec_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eiec_merge: interrupt output merge
// Gates the pending flags with the unmask bits and groups them onto outputs.
// ----------------------------------------------------------------------------
module eiec_merge import eiec_pkg::*; (
	input  logic [LINE_CAP-1:0] pend,
	input  logic [LINE_CAP-1:0] unmask,
	output logic [IRQ_W-1:0]    irq
);

	logic [LINE_CAP-1:0] active;

	assign active = pend & unmask;

	always_comb begin
		irq = '0;
		irq[DIRECT_LINES-1:0] = active[DIRECT_LINES-1:0];
		irq[DIRECT_LINES]     = |active[LAST_SHARED_LOW:DIRECT_LINES];
		irq[DIRECT_LINES+1]   = |active[LINE_CAP-1:LAST_SHARED_LOW+1];
	end

endmodule

>>> design/external_interrupt_edge_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller: sixteen-line edge interrupt controller
// Per-line lanes detect enabled edges on selected port pins, latch pending
// flags and feed a merge stage that drives the grouped interrupt outputs.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Direction | Moves
//  --------+----------------------------------+-----------+--------------------
//  in      | in_valid, in_ready, in_item      | into      | one tick request
//  out     | out_valid, out_ready, out_item   | out of    | one result request
//  cfg     | cfg_valid, cfg_ready, cfg_index, | into      | one register write
//          | cfg_data                         |           |
//
// Each request is accepted, and the lanes and merge stage work on it in
// that same cycle, and the result sits in the output register
// from the next cycle on. One request per cycle is sustained while out_ready
// stays high; the single output register sets that figure.
// Reset clears the configuration registers, every line's previous level and
// pending flag, and the output valid bit.
// While a result waits with out_ready low, in_ready drops and the line state
// holds; the request is taken in the cycle the output register frees up.
// Writes to cfg are always taken; an index past the last register is dropped.
// ----------------------------------------------------------------------------
module external_interrupt_edge_controller import eiec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LINE_CAP-1:0]       line_unmask_q;
	logic [LINE_CAP-1:0]       rise_en_q;
	logic [LINE_CAP-1:0]       fall_en_q;
	logic [LINE_CAP*SEL_W-1:0] port_sel_q;

	logic                      advance;
	logic [15:0]               ports [NUM_PORTS];
	logic [LINE_CAP-1:0]       pend_next;
	logic [IRQ_W-1:0]          irq_next;
	logic                      out_valid_q;
	out_item_t                 out_item_q;

	// The register file takes every write; the user must write it only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_unmask_q <= '0;
			rise_en_q     <= '0;
			fall_en_q     <= '0;
			port_sel_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_UNMASK:    line_unmask_q <= cfg_data[LINE_CAP-1:0];
				REG_RISING_ENABLE:  rise_en_q     <= cfg_data[LINE_CAP-1:0];
				REG_FALLING_ENABLE: fall_en_q     <= cfg_data[LINE_CAP-1:0];
				REG_PORT_SELECT:    port_sel_q    <= cfg_data[LINE_CAP*SEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The input side runs whenever the output register is empty or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign advance  = in_valid && in_ready;

	// Only the first NUM_PORTS ports exist; the rest are never looked at.
	always_comb begin
		ports[0] = in_item.port0_levels;
		if (NUM_PORTS > 1) ports[1 % NUM_PORTS] = in_item.port1_levels;
		if (NUM_PORTS > 2) ports[2 % NUM_PORTS] = in_item.port2_levels;
		if (NUM_PORTS > 3) ports[3 % NUM_PORTS] = in_item.port3_levels;
	end

	// One lane per present line. Lines past NUM_LINES read as zero.
	for (genvar n = 0; n < LINE_CAP; n++) begin : g_line
		if (n < NUM_LINES) begin : g_lane
			logic [NUM_PORTS-1:0] pins;
			lane_cfg_t            cfg;

			always_comb begin
				for (int p = 0; p < NUM_PORTS; p++) begin
					pins[p] = ports[p][n];
				end
			end

			assign cfg.rise_en = rise_en_q[n];
			assign cfg.fall_en = fall_en_q[n];
			assign cfg.sel     = port_sel_q[n*SEL_W +: SEL_W];

			eiec_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.pins      (pins),
				.clear     (in_item.clear_mask[n]),
				.cfg       (cfg),
				.pend_next (pend_next[n])
			);
		end else begin : g_absent
			assign pend_next[n] = 1'b0;
		end
	end

	eiec_merge u_merge (
		.pend   (pend_next),
		.unmask (line_unmask_q),
		.irq    (irq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.pending_flags <= pend_next;
			out_item_q.irq_lines     <= irq_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> design/eiec_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eiec_chk: port checker of the external interrupt controller
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module eiec_chk import eiec_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A waiting result is held until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped while stalled");

	// A stalled output must block the input side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// Every accepted request shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request gave no result");

	// An interrupt output is raised only by a pending line of its group.
	a_irq_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((out_item.irq_lines[DIRECT_LINES-1:0] &
			  ~out_item.pending_flags[DIRECT_LINES-1:0]) == '0) &&
			(!out_item.irq_lines[DIRECT_LINES] ||
			 (|out_item.pending_flags[LAST_SHARED_LOW:DIRECT_LINES])) &&
			(!out_item.irq_lines[DIRECT_LINES+1] ||
			 (|out_item.pending_flags[LINE_CAP-1:LAST_SHARED_LOW+1])))
		else $error("interrupt raised without a pending line");

endmodule

bind external_interrupt_edge_controller eiec_chk u_eiec_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the external interrupt edge controller
// Tick requests go in through a queue-fed driver with random gaps, and
// results come out under random back-pressure. A line model inside the
// bench predicts the pending flags and interrupt outputs of every tick.
// ----------------------------------------------------------------------------
module tb_top;
	import eiec_pkg::*;

	// The tick request always carries four port fields, whatever NUM_PORTS is.
	localparam int ITEM_PORTS    = 4;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_BATCHES = 2;
	localparam int BATCH_TICKS   = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Requests waiting for the driver, and results the line model expects.
	in_item_t tick_queue[$];
	out_item_t expected_results[$];

	// Line model: its own copy of the registers and of the per-line state.
	logic [15:0] unmask_reg = '0;
	logic [15:0] rise_reg = '0;
	logic [15:0] fall_reg = '0;
	logic [CFG_DATA_W-1:0] port_sel_reg = '0;
	logic [LINE_CAP-1:0] line_prev = '0;
	logic [LINE_CAP-1:0] line_pending = '0;

	int fail_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit tick_taken = 1'b0;
	// When set, neither side inserts gaps or stalls.
	bit quiet_phase = 1'b0;

	external_interrupt_edge_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Advances the line model by one tick and returns the result it predicts.
	// Each line picks its level from the port named by its selector field; a
	// selector past the ports that exist reads as level 0. Clears are applied
	// before the new edges are merged in, so an edge in the same tick wins.
	function automatic out_item_t advance_lines(input in_item_t t);
		logic [15:0] pins [ITEM_PORTS];
		logic [LINE_CAP-1:0] levels;
		logic [LINE_CAP-1:0] edges;
		logic [LINE_CAP-1:0] active;
		logic [LINE_CAP-1:0] present;
		logic [SEL_W-1:0] sel;
		out_item_t r;
		pins[0] = t.port0_levels;
		pins[1] = t.port1_levels;
		pins[2] = t.port2_levels;
		pins[3] = t.port3_levels;
		present = (NUM_LINES >= LINE_CAP) ? {LINE_CAP{1'b1}} :
			LINE_CAP'((1 << NUM_LINES) - 1);
		levels = '0;
		for (int ln = 0; ln < LINE_CAP; ln++) begin
			sel = port_sel_reg[ln*SEL_W +: SEL_W];
			if (sel < NUM_PORTS && sel < ITEM_PORTS)
				levels[ln] = pins[sel][ln];
		end
		levels &= present;
		edges = ((levels & ~line_prev & rise_reg) | (~levels & line_prev & fall_reg)) & present;
		line_pending = ((line_pending & ~t.clear_mask) | edges) & present;
		line_prev = levels;
		// Pending flags latch whether or not a line is unmasked; only the
		// interrupt outputs honor the mask.
		active = line_pending & unmask_reg;
		r.pending_flags = line_pending;
		r.irq_lines = '0;
		r.irq_lines[DIRECT_LINES-1:0] = active[DIRECT_LINES-1:0];
		r.irq_lines[DIRECT_LINES] = |active[LAST_SHARED_LOW:DIRECT_LINES];
		r.irq_lines[DIRECT_LINES+1] = |active[LINE_CAP-1:LAST_SHARED_LOW+1];
		return r;
	endfunction

	// Gap length for the sender and stall length for the receiver: mostly
	// none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// A 16-bit register value: an extreme or a random pattern, with random
	// junk above bit 15 that the block must drop.
	function automatic logic [CFG_DATA_W-1:0] pick_mask_data(input int phase);
		logic [15:0] v;
		int r;
		r = $urandom_range(0, 9);
		if (phase == 0 || r == 0)
			v = 16'hFFFF;
		else if (phase == 1 || r == 1)
			v = 16'h0000;
		else
			v = 16'($urandom);
		return {32'($urandom), 16'($urandom), v};
	endfunction

	// Selector fields lean toward ports that exist, but every field value
	// comes up now and then.
	function automatic logic [CFG_DATA_W-1:0] pick_port_select(input int phase);
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		if (phase == 2)
			return '1;
		if (phase == 3)
			return '0;
		for (int ln = 0; ln < LINE_CAP; ln++) begin
			if ($urandom_range(0, 3) != 0)
				v[ln*SEL_W +: SEL_W] = SEL_W'($urandom_range(0, NUM_PORTS - 1));
			else
				v[ln*SEL_W +: SEL_W] = SEL_W'($urandom);
		end
		return v;
	endfunction

	function automatic void queue_tick(input logic [15:0] p0, input logic [15:0] p1,
			input logic [15:0] p2, input logic [15:0] p3, input logic [15:0] clr);
		in_item_t t;
		t.port0_levels = p0;
		t.port1_levels = p1;
		t.port2_levels = p2;
		t.port3_levels = p3;
		t.clear_mask = clr;
		tick_queue.push_back(t);
	endfunction

	// One register write. Writes only happen while no tick is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Returns once every queued tick has been sent and every result is back.
	// Each tick yields exactly one result, so nothing can still be at work.
	task automatic wait_drained();
		do @(posedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// Sender. A new request is presented only when the previous one was taken
	// at the last rising edge or nothing is on offer; otherwise valid and the
	// payload hold.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || tick_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (tick_queue.size() > 0) begin
				in_item <= tick_queue.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Monitor. Everything here is sampled at the rising edge, before the
	// block's own registers update. Results are checked before the new tick
	// is predicted, though the order does not matter: a result accepted now
	// belongs to a tick accepted at an earlier edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			cycle_count++;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no tick outstanding: pending_flags %h irq_lines %h",
						out_item.pending_flags, out_item.irq_lines);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_item.pending_flags !== want.pending_flags) begin
						$error("pending_flags: expected %h, got %h",
							want.pending_flags, out_item.pending_flags);
						fail_count++;
					end
					if (out_item.irq_lines !== want.irq_lines) begin
						$error("irq_lines: expected %h, got %h",
							want.irq_lines, out_item.irq_lines);
						fail_count++;
					end
				end
			end
			tick_taken = in_valid && in_ready;
			if (tick_taken)
				expected_results.push_back(advance_lines(in_item));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LINE_UNMASK: begin
						unmask_reg = cfg_data[15:0];
					end
					REG_RISING_ENABLE: begin
						rise_reg = cfg_data[15:0];
					end
					REG_FALLING_ENABLE: begin
						fall_reg = cfg_data[15:0];
					end
					REG_PORT_SELECT: begin
						port_sel_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Watchdog for a block that stops answering.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [15:0] pins [ITEM_PORTS];
		logic [15:0] clr;
		int r;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Only rising edges enabled, everything else at reset. The first tick
		// after reset compares against a previous level of zero, so lines
		// that start high show a rising edge; masked lines still latch.
		write_reg(REG_RISING_ENABLE, 64'h0000_0000_0000_FFFF);
		queue_tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		queue_tick(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		queue_tick(16'h00FF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0F0F);
		wait_drained();

		// Both edges on every line, all lines unmasked, four lines per port.
		write_reg(REG_FALLING_ENABLE, 64'h0000_0000_0000_FFFF);
		write_reg(REG_LINE_UNMASK, 64'h0000_0000_0000_FFFF);
		write_reg(REG_PORT_SELECT, 64'h3333_2222_1111_0000);
		queue_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		queue_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// Every line falls while its flag is cleared: the edge wins.
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		queue_tick(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF);
		queue_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hFFFF);
		queue_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hFFFF);
		wait_drained();

		// Lines 4..15 select ports that do not exist and must read as low.
		// Junk above the 16-bit registers is dropped, and a write to an index
		// past the last register changes nothing.
		write_reg(REG_PORT_SELECT, 64'hFEDC_BA98_7654_3210);
		write_reg(REG_RISING_ENABLE, 64'hFFFF_FFFF_FFFF_5555);
		write_reg(REG_FALLING_ENABLE, 64'hDEAD_BEEF_0000_AAAA);
		write_reg(REG_LINE_UNMASK, 64'hFFFF_0000_FFFF_0421);
		write_reg(REG_PORT_SELECT + 1'b1, '1);
		write_reg({CFG_IDX_W{1'b1}}, '0);
		queue_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		queue_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		wait_drained();

		// One unmasked line in each shared group, every line on port 3.
		write_reg(REG_LINE_UNMASK, 64'h0000_0000_0000_0420);
		write_reg(REG_PORT_SELECT, 64'h3333_3333_3333_3333);
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFBDF);
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0420);
		queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		wait_drained();

		for (int k = 0; k < ITEM_PORTS; k++)
			pins[k] = '0;

		// Random phases. Each one reprograms some registers, sometimes with a
		// write to an unused index, then sends its ticks in batches. Between
		// batches the sender holds off until every result is back.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			quiet_phase = (phase % 4 == 1);
			if (phase < 4 || $urandom_range(0, 9) < 7)
				write_reg(REG_LINE_UNMASK, pick_mask_data(phase));
			if (phase < 4 || $urandom_range(0, 9) < 7)
				write_reg(REG_RISING_ENABLE, pick_mask_data(phase));
			if (phase < 4 || $urandom_range(0, 9) < 7)
				write_reg(REG_FALLING_ENABLE, pick_mask_data(phase));
			if (phase < 4 || $urandom_range(0, 9) < 7)
				write_reg(REG_PORT_SELECT, pick_port_select(phase));
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_PORT_SELECT + 1,
					(1 << CFG_IDX_W) - 1)), {$urandom, $urandom});

			for (int batch = 0; batch < PHASE_BATCHES; batch++) begin
				for (int n = 0; n < BATCH_TICKS; n++) begin
					// Pins half the time hold with a few toggles so flags build up
					// and wait for clears; otherwise they change wholesale.
					for (int k = 0; k < ITEM_PORTS; k++) begin
						if ($urandom_range(0, 1) != 0)
							pins[k] = pins[k] ^ 16'($urandom & $urandom & $urandom);
						else
							pins[k] = 16'($urandom);
					end
					r = $urandom_range(0, 9);
					if (r < 4)
						clr = '0;
					else if (r < 8)
						clr = 16'($urandom);
					else if (r == 8)
						clr = 16'h1 << $urandom_range(0, 15);
					else
						clr = '1;
					queue_tick(pins[0], pins[1], pins[2], pins[3], clr);
				end
				wait_drained();
			end
		end

		quiet_phase = 1'b0;
		wait_drained();
		// Give a stray extra result time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
